// File: sv/olst_pkg.sv
// olst_pkg: shared constants, types and codes of the ordered list store
// used by the cell row, the first-match finder and the top level
`timescale 1ns / 1ps

package olst_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 7;
  localparam int ACT_W      = 3;
  localparam int STAT_W     = 2;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_INSERT     = 3'd4,
    ACT_ERASE      = 3'd5,
    ACT_FIND       = 3'd6
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // per-cell control for one transaction
  typedef struct packed {
    logic load;       // take the new value
    logic from_left;  // take the neighbour below (shift up)
    logic from_right; // take the neighbour above (shift down)
    logic cmp_en;     // capture the compare result
    logic valid;      // cell lies below the element count
  } cell_ctl_t;

endpackage

// File: sv/olst_cell.sv
// olst_cell: one entry of the list, with its neighbour links and a
// registered equality flag; uses olst_pkg
`timescale 1ns / 1ps

module olst_cell (
  input  logic              clk,
  input  olst_pkg::cell_ctl_t ctl,
  input  olst_pkg::data_t   left_data,
  input  olst_pkg::data_t   right_data,
  input  olst_pkg::data_t   new_data,
  output olst_pkg::data_t   data,
  output logic              hit
);
  import olst_pkg::*;

  data_t data_r;
  logic  hit_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= new_data;
    end else if (ctl.from_left) begin
      data_r <= left_data;
    end else if (ctl.from_right) begin
      data_r <= right_data;
    end
    // compare uses the contents before this transaction's shift
    if (ctl.cmp_en) begin
      hit_r <= ctl.valid && (data_r == new_data);
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

// File: sv/olst_first_match.sv
// olst_first_match: lowest set bit of the cell hit vector and its index
// uses olst_pkg
`timescale 1ns / 1ps

module olst_first_match (
  input  logic [olst_pkg::CAPACITY-1:0] hits,
  output logic                          found,
  output olst_pkg::idx_t                index
);
  import olst_pkg::*;

  logic [CAPACITY-1:0] lowest;
  idx_t                idx_acc;

  // isolate the lowest hit, then encode the single remaining bit
  assign lowest = hits & (~hits + CAPACITY'(1));

  always_comb begin
    idx_acc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lowest[i]) begin
        idx_acc = idx_acc | IDX_W'(i);
      end
    end
  end

  assign found = |hits;
  assign index = idx_acc;

endmodule

// File: sv/ordered_list_store_core.sv
// ordered_list_store_core: top level of the ordered list store
// uses olst_pkg, olst_cell and olst_first_match
`timescale 1ns / 1ps

// Ordered list of up to 64 signed 32-bit values held in a row of cells. On the
// accepting edge the cells from the insert or erase point on shift by one
// place towards or away from that point, and all cells capture their compare
// against in_value in parallel; in the resolve state, once the output register
// is free, the lowest hit is encoded and the result is written to the output
// register. A new request is taken once that result is registered, even while
// it waits on out_ready. Failed requests (full, empty, position out of range)
// leave the list unchanged.
module ordered_list_store_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [olst_pkg::ACT_W-1:0]  in_action,
  input  logic [olst_pkg::POS_W-1:0]  in_position,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [olst_pkg::STAT_W-1:0] out_status,
  output logic                        out_found,
  output logic [olst_pkg::IDX_W-1:0]  out_found_index,
  output logic [olst_pkg::CNT_W-1:0]  out_count
);
  import olst_pkg::*;

  typedef enum logic {S_IDLE, S_RESOLVE} state_t;

  state_t  state_r;
  cnt_t    count_r;
  status_t pend_status_r;
  logic    pend_find_r;
  logic    out_valid_r;
  status_t out_status_r;
  logic    out_found_r;
  idx_t    out_index_r;
  cnt_t    out_count_r;

  logic    accept;
  action_t act;
  cnt_t    pos;
  status_t status_nxt;
  cnt_t    count_nxt;
  logic    do_ins;
  logic    do_era;
  cnt_t    op_pos;
  data_t   new_val;

  data_t               cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_hits;
  logic                fm_found;
  idx_t                fm_index;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign act      = action_t'(in_action);
  assign pos      = CNT_W'(in_position);
  assign new_val  = data_t'(in_value);

  // decode the request against the current count
  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    do_ins     = 1'b0;
    do_era     = 1'b0;
    op_pos     = '0;
    unique case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else if (act == ACT_INSERT && pos > count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          op_pos    = (act == ACT_PUSH_FRONT) ? '0 :
                      (act == ACT_PUSH_BACK) ? count_r : pos;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_era    = (act == ACT_POP_FRONT);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_ERASE: begin
        if (pos >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          do_era    = 1'b1;
          op_pos    = pos;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_FIND: begin
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam cnt_t Idx = CNT_W'(g);
    cell_ctl_t ctl;

    always_comb begin
      ctl.load       = accept && do_ins && (Idx == op_pos);
      ctl.from_left  = accept && do_ins && (Idx > op_pos) && (Idx <= count_r);
      ctl.from_right = accept && do_era && (Idx >= op_pos)
                       && ((Idx + CNT_W'(1)) < count_r);
      ctl.cmp_en     = accept;
      ctl.valid      = (Idx < count_r);
    end

    olst_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  ((g == 0) ? data_t'('0) : cell_data[(g == 0) ? 0 : g - 1]),
      .right_data ((g == CAPACITY - 1) ? data_t'('0)
                   : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
      .new_data   (new_val),
      .data       (cell_data[g]),
      .hit        (cell_hits[g])
    );
  end

  olst_first_match u_first_match (
    .hits  (cell_hits),
    .found (fm_found),
    .index (fm_index)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      pend_status_r <= ST_OK;
      pend_find_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            count_r       <= count_nxt;
            pend_status_r <= status_nxt;
            pend_find_r   <= (act == ACT_FIND);
            state_r       <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          // hand over once the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= pend_status_r;
            out_found_r  <= pend_find_r && fm_found;
            out_index_r  <= (pend_find_r && fm_found) ? fm_index : '0;
            out_count_r  <= count_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_index_r;
  assign out_count       = out_count_r;

endmodule

// File: dv/ordered_list_store_core_test.sv
// ordered_list_store_core_test: self-checking testbench for the ordered list store core
// depends on olst_pkg and ordered_list_store_core; keeps a shadow list and checks each reply
`timescale 1ns / 1ps

module ordered_list_store_core_test;
  import olst_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 1000;
  localparam int PHASE_LEN   = 100;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

  typedef struct {
    status_t status;
    logic    found;
    idx_t    index;
    cnt_t    count;
  } list_reply_t;

  // shadow copy of the list; works out the reply of every accepted request
  class list_tracker;
    data_t       cells[CAPACITY];
    int          fill;
    list_reply_t expected_replies[$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos, data_t val);
      list_reply_t r;
      int          slot;
      r.status = ST_OK;
      r.found  = 1'b0;
      r.index  = '0;
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
          slot = (act == ACT_PUSH_FRONT) ? 0 : (act == ACT_PUSH_BACK) ? fill : int'(pos);
          // full is reported ahead of a bad position
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else if (slot > fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = fill; i > slot; i--) cells[i] = cells[i-1];
            cells[slot] = val;
            fill++;
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (act == ACT_POP_FRONT) begin
              for (int i = 0; i + 1 < fill; i++) cells[i] = cells[i+1];
            end
            fill--;
          end
        end
        ACT_ERASE: begin
          if (int'(pos) >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = int'(pos); i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        ACT_FIND: begin
          for (int i = 0; i < fill; i++) begin
            if (cells[i] == val) begin
              r.found = 1'b1;
              r.index = idx_t'(i);
              break;
            end
          end
        end
        default: ;
      endcase
      r.count = cnt_t'(fill);
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [STAT_W-1:0] st, logic f, idx_t ix, cnt_t c);
      list_reply_t e;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with nothing outstanding, expected none, got status %0d count %0d",
                 $time, st, c);
        errors++;
      end else begin
        e = expected_replies.pop_front();
        compare_field("status", e.status, st);
        compare_field("found", e.found, f);
        compare_field("found_index", e.index, ix);
        compare_field("count", e.count, c);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [ACT_W-1:0]     in_action;
  logic [POS_W-1:0]     in_position;
  logic signed [31:0]   in_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    out_status;
  logic                 out_found;
  idx_t                 out_found_index;
  cnt_t                 out_count;

  list_tracker tracker = new();
  int          burst_left = 0;
  int          idle_cycles = 0;
  bit          hold_req = 1'b0;

  ordered_list_store_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_request(in_action, in_position, in_value);
      if (out_valid && out_ready) begin
        tracker.check_reply(out_status, out_found, out_found_index, out_count);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
          $display("** ordered_list_store_core: FAILED **");
          $finish;
        end
      end
    end
  end

  // receiver: changes its stall pattern every so often, plus one long hold-off on request
  initial begin
    int rx_left;
    int rx_mode;
    int tick;
    rx_left = 0;
    rx_mode = 0;
    tick    = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 100);
        end
        rx_left--;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= ((tick / 7) % 3 == 0);
        endcase
      end
    end
  end

  function automatic data_t pick_value();
    data_t pool[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                       32'hffff_ffff, 32'h0000_0001, 32'h5555_aaaa};
    if ($urandom_range(0, 9) < 4) return pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // offers one transaction in bursts with random gaps; returns on the falling edge
  // after it has been accepted
  task automatic send_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos, data_t val);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (tracker.expected_replies.size() != 0) @(negedge clk);
  endtask

  initial begin
    phase_t           kind;
    int               r;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    data_t            val;
    int               choice;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = ACT_PUSH_FRONT;
    in_position = '0;
    in_value    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list corner cases
    send_request(ACT_FIND, 7'd0, 32'h0);
    send_request(ACT_POP_FRONT, 7'd0, 32'h0);
    send_request(ACT_POP_BACK, 7'd0, 32'h0);
    send_request(ACT_ERASE, 7'd0, 32'h0);
    send_request(ACT_INSERT, 7'd1, 32'h1234);
    // value extremes and duplicates
    send_request(ACT_INSERT, 7'd0, 32'h8000_0000);
    send_request(ACT_PUSH_BACK, 7'd127, 32'h7fff_ffff);
    send_request(ACT_PUSH_FRONT, 7'd64, 32'hffff_ffff);
    send_request(ACT_PUSH_BACK, 7'd0, 32'h0);
    send_request(ACT_INSERT, 7'd2, 32'h7fff_ffff);
    send_request(ACT_FIND, 7'd127, 32'h7fff_ffff);
    send_request(ACT_FIND, 7'd0, 32'h8000_0000);
    send_request(ACT_FIND, 7'd0, 32'h0000_3039);
    // position bounds
    send_request(ACT_INSERT, 7'd127, 32'haaaa_5555);
    send_request(ACT_INSERT, POS_W'(tracker.fill + 1), 32'h0f0f_0f0f);
    send_request(ACT_INSERT, POS_W'(tracker.fill), 32'hf0f0_f0f0);
    send_request(ACT_ERASE, 7'd64, 32'h0);
    send_request(ACT_ERASE, POS_W'(tracker.fill), 32'h0);
    send_request(ACT_ERASE, 7'd0, 32'h0);
    send_request(ACT_ERASE, POS_W'(tracker.fill - 1), 32'h0);
    send_request(ACT_UNUSED, 7'd127, 32'hdead_beef);
    send_request(ACT_POP_FRONT, 7'd0, 32'h0);
    send_request(ACT_POP_BACK, 7'd0, 32'h0);
    send_request(ACT_FIND, 7'd0, 32'hffff_ffff);

    for (int ph = 0; ph < RAND_ITEMS / PHASE_LEN; ph++) begin
      kind = phase_t'(ph % 3);
      // long receiver stall while requests keep coming
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        case (kind)
          PH_FILL: begin
            act = (r < 30) ? ACT_PUSH_BACK : (r < 50) ? ACT_PUSH_FRONT :
                  (r < 80) ? ACT_INSERT : (r < 88) ? ACT_FIND :
                  (r < 92) ? ACT_POP_FRONT : (r < 95) ? ACT_POP_BACK :
                  (r < 98) ? ACT_ERASE : ACT_UNUSED;
          end
          PH_DRAIN: begin
            act = (r < 10) ? ACT_PUSH_BACK : (r < 15) ? ACT_PUSH_FRONT :
                  (r < 25) ? ACT_INSERT : (r < 35) ? ACT_FIND :
                  (r < 55) ? ACT_POP_FRONT : (r < 75) ? ACT_POP_BACK :
                  (r < 97) ? ACT_ERASE : ACT_UNUSED;
          end
          default: begin
            act = (r < 97) ? ACT_W'($urandom_range(0, 6)) : ACT_UNUSED;
          end
        endcase
        choice = $urandom_range(0, 9);
        if (choice < 8) begin
          pos = POS_W'($urandom_range(0, tracker.fill + 1));
        end else if (choice == 8) begin
          pos = POS_W'(tracker.fill);
        end else begin
          pos = POS_W'($urandom_range(0, 127));
        end
        // half of the searches on a non-empty list look for something that is actually stored
        if (act == ACT_FIND && tracker.fill > 0 && $urandom_range(0, 1) == 1) begin
          val = tracker.cells[$urandom_range(0, tracker.fill - 1)];
        end else begin
          val = pick_value();
        end
        send_request(act, pos, val);
      end
      if (ph == 1 || ph == 6) wait_for_replies();
    end

    wait_for_replies();
    repeat (20) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("** ordered_list_store_core: PASSED **");
    end else begin
      $display("** ordered_list_store_core: FAILED **");
    end
    $finish;
  end

endmodule
